>>> design/xmr_pkg.sv
package xmr_pkg;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [10:0] SHORT_BLOCK = 11'd128;
    localparam logic [10:0] LONG_BLOCK  = 11'd1024;
    localparam logic [7:0] SYNC_TRIES_RESET  = 8'd30;
    localparam logic [7:0] MAX_REPEATS_RESET = 8'd25;
    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_BYTE    = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    localparam logic [1:0] VD_NONE   = 2'd0;
    localparam logic [1:0] VD_ACCEPT = 2'd1;
    localparam logic [1:0] VD_DUP    = 2'd2;
    localparam logic [1:0] VD_REJECT = 2'd3;

    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_CANCEL = 2'd1;
    localparam logic [1:0] ST_SYNC   = 2'd2;
    localparam logic [1:0] ST_REPEAT = 2'd3;

    localparam logic CFG_SYNC_TRIES  = 1'b0;
    localparam logic CFG_MAX_REPEATS = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE, PH_SYNC, PH_BLOCK, PH_FLUSH, PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        PA_NONE, PA_ACK_END, PA_ACK_CANCEL, PA_NAK, PA_CAN_SYNC, PA_CAN_REPEAT
    } pend_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [1:0]  verdict;
        logic        done_res;
        logic [1:0]  status;
        logic [23:0] byte_count;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] n;
        out_item_t  r0;
        out_item_t  r1;
        out_item_t  r2;
    } step_res_t;

    function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

>>> design/xmr_out_queue.sv
module xmr_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  xmr_pkg::step_res_t  res,
    output logic                busy,
    output logic                m_valid,
    input  logic                m_ready,
    output xmr_pkg::out_item_t  m_data
);

    xmr_pkg::out_item_t q_reg [3];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] rd_reg, rd_next;

    // busy when more than one beat still waits, or one that is not leaving
    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = q_reg[rd_reg];
    assign busy    = (cnt_reg > 2'd1) || (cnt_reg == 2'd1 && !m_ready);

    always_comb begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (m_valid && m_ready) begin
            cnt_next = cnt_reg - 2'd1;
            rd_next  = rd_reg + 2'd1;
        end
        if (load && res.n != 2'd0) begin
            cnt_next = res.n;
            rd_next  = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
        if (load && res.n != 2'd0) begin
            q_reg[0] <= res.r0;
            q_reg[1] <= res.r1;
            q_reg[2] <= res.r2;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3 || rd_reg == 2'd0) else $error("queue read pointer off");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && !load) |=> m_valid) else $error("beat dropped");
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd1) |-> m_data.last) else $error("final beat lacks last");
`endif

endmodule

>>> design/xmr_engine.sv
module xmr_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                step,
    input  xmr_pkg::in_item_t   item,
    output xmr_pkg::step_res_t  res
);

    logic [7:0] sync_tries_reg, max_repeats_reg;
    xmr_pkg::phase_t phase_reg, phase_next;
    xmr_pkg::pend_t  pend_reg, pend_next;
    logic [7:0]  try_char_reg, try_char_next;
    logic        crc_mode_reg, crc_mode_next;
    logic [7:0]  exp_reg, exp_next;
    logic [7:0]  try_cnt_reg, try_cnt_next;
    logic [7:0]  credit_reg, credit_next;
    logic        cancel_reg, cancel_next;
    logic        long_reg, long_next;
    logic [10:0] idx_reg, idx_next;
    logic [7:0]  bnum_reg, bnum_next;
    logic [7:0]  bcomp_reg, bcomp_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  sent_reg, sent_next;
    logic [23:0] acc_reg, acc_next;

    logic [1:0]  act;
    logic [7:0]  b;
    logic        tout;
    logic [10:0] size;
    logic [24:0] acc_sum;
    logic        ok, chk_ok, judge_now, abort_now, is_new;
    logic [7:0]  tc_inc, nt_try_char;
    logic [1:0]  vd;

    xmr_pkg::out_item_t e0, e1, e2;
    logic [1:0] n;

    assign act  = item.action;
    assign b    = item.rx_byte;
    assign tout = (act == xmr_pkg::ACT_TIMEOUT) || (act == xmr_pkg::ACT_BYTE && b == 8'h00);
    assign size = long_reg ? xmr_pkg::LONG_BLOCK : xmr_pkg::SHORT_BLOCK;
    assign tc_inc = (try_cnt_reg == 8'hFF) ? try_cnt_reg : try_cnt_reg + 8'd1;

    function automatic xmr_pkg::out_item_t mk(logic tv, logic [7:0] tb, logic dv,
        logic [7:0] db, logic [1:0] v, logic dn, logic [1:0] st, logic [23:0] bc);
        xmr_pkg::out_item_t r;
        r.tx_valid = tv; r.tx_byte = tb; r.data_valid = dv; r.data_byte = db;
        r.verdict = v; r.done_res = dn; r.status = st; r.byte_count = bc;
        r.last = 1'b0;
        return r;
    endfunction

    always_comb begin
        phase_next = phase_reg; pend_next = pend_reg;
        try_char_next = try_char_reg; crc_mode_next = crc_mode_reg;
        exp_next = exp_reg; try_cnt_next = try_cnt_reg; credit_next = credit_reg;
        cancel_next = cancel_reg; long_next = long_reg; idx_next = idx_reg;
        bnum_next = bnum_reg; bcomp_next = bcomp_reg; crc_next = crc_reg;
        sum_next = sum_reg; sent_next = sent_reg; acc_next = acc_reg;
        e0 = '0; e1 = '0; e2 = '0; n = 2'd0;
        judge_now = 1'b0; chk_ok = 1'b0; ok = 1'b0; abort_now = 1'b0;
        is_new = 1'b0; vd = xmr_pkg::VD_NONE; acc_sum = '0;
        nt_try_char = try_char_reg;

        if (act == xmr_pkg::ACT_START) begin
            phase_next = xmr_pkg::PH_SYNC; try_char_next = xmr_pkg::CH_C;
            crc_mode_next = 1'b0; exp_next = 8'd1; try_cnt_next = 8'd0;
            credit_next = max_repeats_reg; cancel_next = 1'b0; long_next = 1'b0;
            idx_next = '0; bnum_next = '0; bcomp_next = '0; crc_next = '0;
            sum_next = '0; sent_next = '0; pend_next = xmr_pkg::PA_NONE;
            acc_next = '0;
            e0 = mk(1'b1, xmr_pkg::CH_C, 1'b0, 8'h00, xmr_pkg::VD_NONE, 1'b0,
                    xmr_pkg::ST_NORMAL, 24'd0);
            n = 2'd1;
        end else if (act == 2'd3) begin
            n = 2'd0;
        end else begin
            case (phase_reg)
                xmr_pkg::PH_SYNC: begin
                    // next_try or consume
                    if ((cancel_reg && !(!tout && b == xmr_pkg::CH_CAN)) ||
                        (!cancel_reg && (tout || !(b == xmr_pkg::CH_SOH ||
                         b == xmr_pkg::CH_STX || b == xmr_pkg::CH_EOT ||
                         b == xmr_pkg::CH_CAN)))) begin
                        cancel_next = 1'b0;
                        try_cnt_next = tc_inc;
                        if (tc_inc < sync_tries_reg) begin
                            if (try_char_reg != 8'h00) begin
                                e0 = mk(1'b1, try_char_reg, 1'b0, 8'h00,
                                        xmr_pkg::VD_NONE, 1'b0, xmr_pkg::ST_NORMAL,
                                        acc_reg);
                                n = 2'd1;
                            end
                        end else if (try_char_reg == xmr_pkg::CH_C) begin
                            try_char_next = xmr_pkg::CH_NAK;
                            try_cnt_next = 8'd0;
                            e0 = mk(1'b1, xmr_pkg::CH_NAK, 1'b0, 8'h00,
                                    xmr_pkg::VD_NONE, 1'b0, xmr_pkg::ST_NORMAL, acc_reg);
                            n = 2'd1;
                        end else begin
                            phase_next = xmr_pkg::PH_FLUSH;
                            pend_next = xmr_pkg::PA_CAN_SYNC;
                        end
                    end else if (cancel_reg) begin
                        cancel_next = 1'b0;
                        phase_next = xmr_pkg::PH_FLUSH;
                        pend_next = xmr_pkg::PA_ACK_CANCEL;
                    end else if (b == xmr_pkg::CH_SOH || b == xmr_pkg::CH_STX) begin
                        if (try_char_reg == xmr_pkg::CH_C) crc_mode_next = 1'b1;
                        try_char_next = 8'h00;
                        long_next = (b == xmr_pkg::CH_STX);
                        idx_next = '0; crc_next = '0; sum_next = '0; sent_next = '0;
                        phase_next = xmr_pkg::PH_BLOCK;
                    end else if (b == xmr_pkg::CH_EOT) begin
                        phase_next = xmr_pkg::PH_FLUSH;
                        pend_next = xmr_pkg::PA_ACK_END;
                    end else begin
                        cancel_next = 1'b1;
                    end
                end
                xmr_pkg::PH_BLOCK: begin
                    if (act == xmr_pkg::ACT_TIMEOUT) begin
                        e0 = mk(1'b0, 8'h00, 1'b0, 8'h00, xmr_pkg::VD_REJECT, 1'b0,
                                xmr_pkg::ST_NORMAL, acc_reg);
                        n = 2'd1;
                        phase_next = xmr_pkg::PH_FLUSH;
                        pend_next = xmr_pkg::PA_NAK;
                    end else begin
                        idx_next = idx_reg + 11'd1;
                        if (idx_reg == 11'd0) begin
                            bnum_next = b;
                        end else if (idx_reg == 11'd1) begin
                            bcomp_next = b;
                        end else if (idx_reg < size + 11'd2) begin
                            crc_next = xmr_pkg::crc_update(crc_reg, b);
                            sum_next = sum_reg + b;
                            e0 = mk(1'b0, 8'h00, 1'b1, b, xmr_pkg::VD_NONE, 1'b0,
                                    xmr_pkg::ST_NORMAL, acc_reg);
                            n = 2'd1;
                        end else if (idx_reg == size + 11'd2) begin
                            if (crc_mode_reg) sent_next = b;
                            else begin
                                judge_now = 1'b1;
                                chk_ok = (b == sum_reg);
                            end
                        end else begin
                            judge_now = 1'b1;
                            chk_ok = ({sent_reg, b} == crc_reg);
                        end
                        if (judge_now) begin
                            ok = (bnum_reg == ~bcomp_reg) && chk_ok &&
                                 (bnum_reg == exp_reg || bnum_reg == exp_reg - 8'd1);
                            if (!ok) begin
                                e0 = mk(1'b0, 8'h00, 1'b0, 8'h00, xmr_pkg::VD_REJECT,
                                        1'b0, xmr_pkg::ST_NORMAL, acc_reg);
                                n = 2'd1;
                                phase_next = xmr_pkg::PH_FLUSH;
                                pend_next = xmr_pkg::PA_NAK;
                            end else begin
                                is_new = (bnum_reg == exp_reg);
                                if (is_new) begin
                                    acc_sum = {1'b0, acc_reg} + {14'd0, size};
                                    acc_next = acc_sum[24] ? xmr_pkg::COUNT_MAX
                                                           : acc_sum[23:0];
                                    exp_next = exp_reg + 8'd1;
                                    credit_next = max_repeats_reg;
                                    abort_now = (max_repeats_reg == 8'd0);
                                    vd = xmr_pkg::VD_ACCEPT;
                                end else begin
                                    abort_now = (credit_reg <= 8'd1);
                                    credit_next = (credit_reg != 8'd0) ?
                                                  credit_reg - 8'd1 : 8'd0;
                                    vd = xmr_pkg::VD_DUP;
                                end
                                n = 2'd1;
                                if (abort_now) begin
                                    e0 = mk(1'b0, 8'h00, 1'b0, 8'h00, vd, 1'b0,
                                            xmr_pkg::ST_NORMAL, acc_next);
                                    phase_next = xmr_pkg::PH_FLUSH;
                                    pend_next = xmr_pkg::PA_CAN_REPEAT;
                                end else begin
                                    e0 = mk(1'b1, xmr_pkg::CH_ACK, 1'b0, 8'h00, vd,
                                            1'b0, xmr_pkg::ST_NORMAL, acc_next);
                                    phase_next = xmr_pkg::PH_SYNC;
                                    try_cnt_next = 8'd0; cancel_next = 1'b0;
                                    pend_next = xmr_pkg::PA_NONE;
                                end
                            end
                        end
                    end
                end
                xmr_pkg::PH_FLUSH: begin
                    if (tout) begin
                        pend_next = xmr_pkg::PA_NONE;
                        case (pend_reg)
                            xmr_pkg::PA_ACK_END, xmr_pkg::PA_ACK_CANCEL: begin
                                e0 = mk(1'b1, xmr_pkg::CH_ACK, 1'b0, 8'h00,
                                        xmr_pkg::VD_NONE, 1'b1,
                                        (pend_reg == xmr_pkg::PA_ACK_CANCEL) ?
                                        xmr_pkg::ST_CANCEL : xmr_pkg::ST_NORMAL, acc_reg);
                                n = 2'd1;
                                phase_next = xmr_pkg::PH_DONE;
                            end
                            xmr_pkg::PA_CAN_SYNC, xmr_pkg::PA_CAN_REPEAT: begin
                                e0 = mk(1'b1, xmr_pkg::CH_CAN, 1'b0, 8'h00,
                                        xmr_pkg::VD_NONE, 1'b0, xmr_pkg::ST_NORMAL, acc_reg);
                                e1 = e0;
                                e2 = mk(1'b1, xmr_pkg::CH_CAN, 1'b0, 8'h00,
                                        xmr_pkg::VD_NONE, 1'b1,
                                        (pend_reg == xmr_pkg::PA_CAN_SYNC) ?
                                        xmr_pkg::ST_SYNC : xmr_pkg::ST_REPEAT, acc_reg);
                                n = 2'd3;
                                phase_next = xmr_pkg::PH_DONE;
                            end
                            xmr_pkg::PA_NAK: begin
                                e0 = mk(1'b1, xmr_pkg::CH_NAK, 1'b0, 8'h00,
                                        xmr_pkg::VD_NONE, 1'b0, xmr_pkg::ST_NORMAL, acc_reg);
                                n = 2'd1;
                                phase_next = xmr_pkg::PH_SYNC;
                                try_cnt_next = 8'd0; cancel_next = 1'b0;
                            end
                            default: begin
                                phase_next = xmr_pkg::PH_SYNC;
                                try_cnt_next = 8'd0; cancel_next = 1'b0;
                            end
                        endcase
                    end
                end
                default: n = 2'd0;
            endcase
        end
        case (n)
            2'd1: e0.last = 1'b1;
            2'd2: e1.last = 1'b1;
            2'd3: e2.last = 1'b1;
            default: ;
        endcase
        res.n = n; res.r0 = e0; res.r1 = e1; res.r2 = e2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_tries_reg <= xmr_pkg::SYNC_TRIES_RESET;
            max_repeats_reg <= xmr_pkg::MAX_REPEATS_RESET;
            phase_reg <= xmr_pkg::PH_IDLE; pend_reg <= xmr_pkg::PA_NONE;
            try_char_reg <= xmr_pkg::CH_C; crc_mode_reg <= 1'b0; exp_reg <= 8'd1;
            try_cnt_reg <= '0; credit_reg <= xmr_pkg::MAX_REPEATS_RESET;
            cancel_reg <= 1'b0; long_reg <= 1'b0; idx_reg <= '0; bnum_reg <= '0;
            bcomp_reg <= '0; crc_reg <= '0; sum_reg <= '0; sent_reg <= '0;
            acc_reg <= '0;
        end else begin
            if (cfg_we && cfg_index == xmr_pkg::CFG_SYNC_TRIES) sync_tries_reg <= cfg_data;
            if (cfg_we && cfg_index == xmr_pkg::CFG_MAX_REPEATS) max_repeats_reg <= cfg_data;
            if (step) begin
                phase_reg <= phase_next; pend_reg <= pend_next;
                try_char_reg <= try_char_next; crc_mode_reg <= crc_mode_next;
                exp_reg <= exp_next; try_cnt_reg <= try_cnt_next;
                credit_reg <= credit_next; cancel_reg <= cancel_next;
                long_reg <= long_next; idx_reg <= idx_next; bnum_reg <= bnum_next;
                bcomp_reg <= bcomp_next; crc_reg <= crc_next; sum_reg <= sum_next;
                sent_reg <= sent_next; acc_reg <= acc_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_flush_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == xmr_pkg::PH_FLUSH) |-> (pend_reg != xmr_pkg::PA_NONE))
        else $error("flush without pending answer");
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == xmr_pkg::PH_DONE && item.action != xmr_pkg::ACT_START)
        |-> (res.n == 2'd0)) else $error("result after session end");
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == xmr_pkg::PH_BLOCK) |-> (idx_reg <= size + 11'd3))
        else $error("block index overran");
`endif

endmodule

>>> design/xmodem_receiver.sv
// channel | dir | handshake          | payload
// s_      | in  | s_valid / s_ready  | s_data  (action, rx_byte)
// m_      | out | m_valid / m_ready  | m_data  (one result beat)
// cfg_    | in  | cfg_we             | cfg_index, cfg_data
// one input beat is taken per cycle while s_ready is high and yields zero to three result beats
// results are registered in a three-entry output queue drained one beat a cycle while m_ready is high
// s_ready drops while more than one queued beat still has to leave, or one waits with m_ready low
// reset is synchronous on aresetn low and clears all session state and the queue count and read pointer
module xmodem_receiver (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  xmr_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output xmr_pkg::out_item_t  m_data
);

    xmr_pkg::step_res_t res;
    logic busy, step;

    assign s_ready = !busy;
    assign step    = s_valid && s_ready;

    xmr_engine u_engine (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .step(step), .item(s_data), .res(res)
    );

    xmr_out_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .load(step), .res(res), .busy(busy),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import xmr_pkg::*;

    localparam logic [1:0] ACT_RSVD = 2'd3;

    typedef struct {
        in_item_t  it;
        bit        typed;
        out_item_t ex;
    } dir_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [0:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;

    bit         beat_typed = 1'b0;
    out_item_t  beat_exp = '0;

    int         errors = 0;
    int         beats_sent = 0;
    int         snd_pct = 0;
    int         rcv_pct = 0;

    out_item_t  exp_q[$];
    out_item_t  step_q[$];
    dir_row_t   dir_tab[$];

    // receiver model state
    logic [7:0]  tries_cfg = SYNC_TRIES_RESET;
    logic [7:0]  repeats_cfg = MAX_REPEATS_RESET;
    phase_t      ph = PH_IDLE;
    logic [7:0]  try_ch = CH_C;
    logic        crc_on = 1'b0;
    logic [7:0]  next_blk = 8'd1;
    logic [7:0]  tries = '0;
    logic [7:0]  credit = MAX_REPEATS_RESET;
    logic        can_seen = 1'b0;
    logic        is_long = 1'b0;
    logic [10:0] idx = '0;
    logic [7:0]  blk_no = '0;
    logic [7:0]  blk_cpl = '0;
    logic [15:0] crc_r = '0;
    logic [7:0]  sum_r = '0;
    logic [7:0]  chk_hi = '0;
    pend_t       pend = PA_NONE;
    logic [23:0] good_bytes = '0;

    xmodem_receiver DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        repeat (8) v = v[15] ? ({v[14:0], 1'b0} ^ CRC_POLY) : {v[14:0], 1'b0};
        return v;
    endfunction

    function automatic void emit_res(logic tv, logic [7:0] tb, logic dv, logic [7:0] db,
                                     logic [1:0] vd, logic dn, logic [1:0] st);
        out_item_t r;
        if (step_q.size() >= 3) return;
        r = '{tx_valid: tv, tx_byte: tb, data_valid: dv, data_byte: db, verdict: vd,
              done_res: dn, status: st, byte_count: good_bytes, last: 1'b0};
        step_q.push_back(r);
    endfunction

    function automatic void go_flush(pend_t pa);
        ph = PH_FLUSH;
        pend = pa;
    endfunction

    function automatic void sync_enter();
        ph = PH_SYNC;
        tries = '0;
        can_seen = 1'b0;
        pend = PA_NONE;
    endfunction

    function automatic void try_next();
        if (tries != 8'hFF) tries++;
        if (tries < tries_cfg) begin
            if (try_ch != 8'h00) emit_res(1, try_ch, 0, 0, VD_NONE, 0, ST_NORMAL);
            return;
        end
        if (try_ch == CH_C) begin
            try_ch = CH_NAK;
            tries = '0;
            emit_res(1, CH_NAK, 0, 0, VD_NONE, 0, ST_NORMAL);
            return;
        end
        go_flush(PA_CAN_SYNC);
    endfunction

    function automatic void judge_blk(int size, logic chk_ok);
        logic [24:0] tot;
        logic        abort_now;
        logic [1:0]  vd;
        if (!(blk_no == ~blk_cpl && (blk_no == next_blk || blk_no == next_blk - 8'd1)
              && chk_ok)) begin
            emit_res(0, 0, 0, 0, VD_REJECT, 0, ST_NORMAL);
            go_flush(PA_NAK);
            return;
        end
        if (blk_no == next_blk) begin
            tot = good_bytes + size;
            good_bytes = (tot > COUNT_MAX) ? COUNT_MAX : tot[23:0];
            next_blk++;
            credit = repeats_cfg;
            abort_now = (credit == 8'd0);
            vd = VD_ACCEPT;
        end else begin
            abort_now = (credit <= 8'd1);
            if (credit != 8'd0) credit--;
            vd = VD_DUP;
        end
        if (abort_now) begin
            emit_res(0, 0, 0, 0, vd, 0, ST_NORMAL);
            go_flush(PA_CAN_REPEAT);
        end else begin
            emit_res(1, CH_ACK, 0, 0, vd, 0, ST_NORMAL);
            sync_enter();
        end
    endfunction

    function automatic void predict_beat(in_item_t it, bit typed, out_item_t ex);
        logic       timed;
        int         size;
        int         ix;
        logic [7:0] b;
        pend_t      pa;
        b = it.rx_byte;
        timed = (it.action == ACT_TIMEOUT) || (it.action == ACT_BYTE && b == 8'h00);
        step_q.delete();
        if (it.action == ACT_START) begin
            ph = PH_SYNC; try_ch = CH_C; crc_on = 0; next_blk = 8'd1; tries = '0;
            credit = repeats_cfg; can_seen = 0; is_long = 0; idx = '0; blk_no = '0;
            blk_cpl = '0; crc_r = '0; sum_r = '0; chk_hi = '0; pend = PA_NONE;
            good_bytes = '0;
            emit_res(1, CH_C, 0, 0, VD_NONE, 0, ST_NORMAL);
        end else if (it.action == ACT_RSVD) begin
        end else if (ph == PH_SYNC) begin
            if (can_seen) begin
                can_seen = 0;
                if (!timed && b == CH_CAN) go_flush(PA_ACK_CANCEL);
                else try_next();
            end else if (timed) begin
                try_next();
            end else begin
                case (b)
                    CH_SOH, CH_STX: begin
                        if (try_ch == CH_C) crc_on = 1;
                        try_ch = 8'h00;
                        is_long = (b == CH_STX);
                        idx = '0; crc_r = '0; sum_r = '0; chk_hi = '0;
                        ph = PH_BLOCK;
                    end
                    CH_EOT: go_flush(PA_ACK_END);
                    CH_CAN: can_seen = 1;
                    default: try_next();
                endcase
            end
        end else if (ph == PH_BLOCK) begin
            size = is_long ? LONG_BLOCK : SHORT_BLOCK;
            ix = idx;
            if (it.action == ACT_TIMEOUT) begin
                emit_res(0, 0, 0, 0, VD_REJECT, 0, ST_NORMAL);
                go_flush(PA_NAK);
            end else begin
                idx = idx + 11'd1;
                if (ix == 0) begin
                    blk_no = b;
                end else if (ix == 1) begin
                    blk_cpl = b;
                end else if (ix < size + 2) begin
                    crc_r = crc_next(crc_r, b);
                    sum_r = sum_r + b;
                    emit_res(0, 0, 1, b, VD_NONE, 0, ST_NORMAL);
                end else if (ix == size + 2) begin
                    if (crc_on) chk_hi = b;
                    else judge_blk(size, b == sum_r);
                end else begin
                    judge_blk(size, {chk_hi, b} == crc_r);
                end
            end
        end else if (ph == PH_FLUSH && timed) begin
            pa = pend;
            pend = PA_NONE;
            case (pa)
                PA_ACK_END: begin
                    emit_res(1, CH_ACK, 0, 0, VD_NONE, 1, ST_NORMAL);
                    ph = PH_DONE;
                end
                PA_ACK_CANCEL: begin
                    emit_res(1, CH_ACK, 0, 0, VD_NONE, 1, ST_CANCEL);
                    ph = PH_DONE;
                end
                PA_CAN_SYNC, PA_CAN_REPEAT: begin
                    emit_res(1, CH_CAN, 0, 0, VD_NONE, 0, ST_NORMAL);
                    emit_res(1, CH_CAN, 0, 0, VD_NONE, 0, ST_NORMAL);
                    emit_res(1, CH_CAN, 0, 0, VD_NONE, 1,
                             (pa == PA_CAN_SYNC) ? ST_SYNC : ST_REPEAT);
                    ph = PH_DONE;
                end
                PA_NAK: begin
                    emit_res(1, CH_NAK, 0, 0, VD_NONE, 0, ST_NORMAL);
                    sync_enter();
                end
                default: sync_enter();
            endcase
        end
        if (typed) begin
            step_q.delete();
            step_q.push_back(ex);
        end
        if (step_q.size() > 0) step_q[$].last = 1'b1;
        foreach (step_q[i]) exp_q.push_back(step_q[i]);
    endfunction

    task automatic report_field(string name, logic [23:0] got, logic [23:0] want);
        if (got !== want) begin
            $display("ERROR %s: got %0h want %0h", name, got, want);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        out_item_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (exp_q.size() == 0) begin
                    report_field("unexpected beat", 24'd1, 24'd0);
                end else begin
                    e = exp_q.pop_front();
                    report_field("tx_valid", m_data.tx_valid, e.tx_valid);
                    report_field("tx_byte", m_data.tx_byte, e.tx_byte);
                    report_field("data_valid", m_data.data_valid, e.data_valid);
                    report_field("data_byte", m_data.data_byte, e.data_byte);
                    report_field("verdict", m_data.verdict, e.verdict);
                    report_field("done_res", m_data.done_res, e.done_res);
                    report_field("status", m_data.status, e.status);
                    report_field("byte_count", m_data.byte_count, e.byte_count);
                    report_field("last", m_data.last, e.last);
                end
            end
            if (s_valid && s_ready) predict_beat(s_data, beat_typed, beat_exp);
        end
    end

    always @(posedge aclk) begin
        m_ready <= (rcv_pct == 0) || ($urandom_range(0, 99) >= rcv_pct);
    end

    task automatic send(logic [1:0] a, logic [7:0] b, bit typed = 1'b0,
                        out_item_t ex = '0);
        while (snd_pct != 0 && $urandom_range(0, 99) < snd_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{action: a, rx_byte: b};
        beat_typed <= typed;
        beat_exp <= ex;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (exp_q.size() != 0) @(posedge aclk);
    endtask

    task automatic set_regs(logic [7:0] n_tries, logic [7:0] n_reps);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SYNC_TRIES;
        cfg_data <= n_tries;
        @(posedge aclk);
        cfg_index <= CFG_MAX_REPEATS;
        cfg_data <= n_reps;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tries_cfg = n_tries;
        repeats_cfg = n_reps;
    endtask

    function automatic out_item_t one_res(logic tv, logic [7:0] tb, logic [1:0] vd,
                                          logic dn, logic [1:0] st);
        return '{tx_valid: tv, tx_byte: tb, data_valid: 1'b0, data_byte: 8'h00,
                 verdict: vd, done_res: dn, status: st, byte_count: 24'd0, last: 1'b1};
    endfunction

    function automatic void add_row(logic [1:0] a, logic [7:0] b, bit typed = 1'b0,
                                    out_item_t ex = '0);
        dir_row_t r;
        r.it = '{action: a, rx_byte: b};
        r.typed = typed;
        r.ex = ex;
        dir_tab.push_back(r);
    endfunction

    task automatic run_session(bit want_long);
        int         nblk;
        int         kind;
        int         size;
        logic [7:0] blk;
        logic [7:0] num;
        logic [7:0] b;
        logic [15:0] crc;
        logic [7:0] sum;
        send(ACT_START, 8'($urandom));
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 4))
                0: send(ACT_TIMEOUT, 8'($urandom));
                1: send(ACT_BYTE, 8'h00);
                2: send(ACT_BYTE, 8'($urandom_range(8'h19, 8'hFF)));
                3: begin
                    send(ACT_BYTE, CH_CAN);
                    send(ACT_BYTE, 8'($urandom_range(8'h19, 8'hFF)));
                end
                default: send(ACT_RSVD, 8'($urandom));
            endcase
        end
        blk = 8'd1;
        nblk = want_long ? 1 : $urandom_range(0, 2);
        for (int i = 0; i < nblk; i++) begin
            // 0..5 good, 6 repeat, 7 wrong number, 8 bad check and maybe bad complement, 9 timeout
            kind = $urandom_range(0, 9);
            size = want_long ? LONG_BLOCK : SHORT_BLOCK;
            num = (kind == 6) ? blk - 8'd1 : (kind == 7) ? blk + 8'd5 : blk;
            send(ACT_BYTE, want_long ? CH_STX : CH_SOH);
            send(ACT_BYTE, num);
            send(ACT_BYTE, (kind == 8 && $urandom_range(0, 1)) ? num : ~num);
            crc = '0;
            sum = '0;
            for (int j = 0; j < size; j++) begin
                if (kind == 9 && j == 10) break;
                b = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom);
                crc = crc_next(crc, b);
                sum = sum + b;
                send(ACT_BYTE, b);
            end
            if (kind == 9) begin
                send(ACT_TIMEOUT, 8'($urandom));
                send(ACT_TIMEOUT, 8'($urandom));
            end else begin
                if (kind == 8) begin
                    crc = crc ^ 16'h0101;
                    sum = sum ^ 8'h01;
                end
                if (crc_on) begin
                    send(ACT_BYTE, crc[15:8]);
                    send(ACT_BYTE, crc[7:0]);
                end else begin
                    send(ACT_BYTE, sum);
                end
                if (kind >= 7) begin
                    send(ACT_BYTE, 8'($urandom_range(1, 255)));
                    send(ACT_BYTE, 8'h00);
                end else if (kind < 6) begin
                    blk = blk + 8'd1;
                end
            end
        end
        case ($urandom_range(0, 2))
            0: begin
                send(ACT_BYTE, CH_EOT);
                send(ACT_TIMEOUT, 8'($urandom));
            end
            1: begin
                send(ACT_BYTE, CH_CAN);
                send(ACT_BYTE, CH_CAN);
                send(ACT_TIMEOUT, 8'($urandom));
            end
            default: repeat ((tries_cfg < 6) ? 2 * tries_cfg + 3 : 4)
                send(ACT_TIMEOUT, 8'($urandom));
        endcase
    endtask

    initial begin
        logic [7:0] cfg_tries[5];
        logic [7:0] cfg_reps[5];
        int         snd_tab[5];
        int         rcv_tab[5];
        int         start_cnt;
        bit         first;
        cfg_tries = '{SYNC_TRIES_RESET, 8'd1, 8'd255, 8'd0, 8'd3};
        cfg_reps  = '{MAX_REPEATS_RESET, 8'd1, 8'd255, 8'd0, 8'd2};
        snd_tab   = '{0, 50, 0, 16, 0};
        rcv_tab   = '{0, 0, 50, 16, 0};

        add_row(ACT_START, 8'hA5, 1, one_res(1, CH_C, VD_NONE, 0, ST_NORMAL));
        add_row(ACT_TIMEOUT, 8'h00);
        add_row(ACT_BYTE, 8'h00);
        add_row(ACT_BYTE, 8'hFF);
        add_row(ACT_RSVD, 8'hFF);
        add_row(ACT_BYTE, CH_CAN);
        add_row(ACT_BYTE, 8'h41);
        add_row(ACT_BYTE, CH_CAN);
        add_row(ACT_BYTE, CH_CAN);
        add_row(ACT_BYTE, 8'h7E);
        add_row(ACT_TIMEOUT, 8'h00, 1, one_res(1, CH_ACK, VD_NONE, 1, ST_CANCEL));
        add_row(ACT_TIMEOUT, 8'h00);
        add_row(ACT_BYTE, 8'h55);
        add_row(ACT_START, 8'h00, 1, one_res(1, CH_C, VD_NONE, 0, ST_NORMAL));
        add_row(ACT_BYTE, CH_EOT);
        add_row(ACT_BYTE, 8'h00, 1, one_res(1, CH_ACK, VD_NONE, 1, ST_NORMAL));
        add_row(ACT_START, 8'h5A);
        add_row(ACT_BYTE, CH_SOH);
        add_row(ACT_BYTE, 8'h01);
        add_row(ACT_BYTE, 8'hFE);
        add_row(ACT_BYTE, 8'h80);
        add_row(ACT_TIMEOUT, 8'h00, 1, one_res(0, 8'h00, VD_REJECT, 0, ST_NORMAL));
        add_row(ACT_TIMEOUT, 8'h00);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) send(dir_tab[i].it.action, dir_tab[i].it.rx_byte,
                                  dir_tab[i].typed, dir_tab[i].ex);

        for (int p = 0; p < 5; p++) begin
            wait_drain();
            repeat (8) @(posedge aclk);
            if (p > 0) set_regs(cfg_tries[p], cfg_reps[p]);
            snd_pct = snd_tab[p];
            rcv_pct = rcv_tab[p];
            start_cnt = beats_sent;
            first = 1'b1;
            while (first || beats_sent - start_cnt < 90) begin
                // hold the sender until all results of the last session are out
                if (p == 2) wait_drain();
                run_session(p == 0 && first);
                first = 1'b0;
            end
        end

        wait_drain();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
design/xmr_pkg.sv
design/xmr_out_queue.sv
design/xmr_engine.sv
design/xmodem_receiver.sv
tb/tb.sv
